[src/fsp_pkg.sv]
// fsp_pkg: shared types, codes and helper functions for the format specifier parser.
// Used by fsp_in_stage, fsp_parser and format_specifier_parser_core.
// No dependencies.
package fsp_pkg;

   localparam int CharW  = 8;
   localparam int ArgW   = 32;
   localparam int WidthW = 31;
   localparam int PrecW  = 32;
   localparam int CountW = 10;

   localparam logic [WidthW-1:0] WIDTH_MAX = {WidthW{1'b1}};
   localparam logic [PrecW-1:0]  PREC_NONE = {PrecW{1'b1}};
   localparam logic [CountW-1:0] COUNT_MAX = {CountW{1'b1}};

   localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
   localparam logic [CharW-1:0] CH_NINE  = 8'h39;
   localparam logic [CharW-1:0] CH_MINUS = 8'h2d;
   localparam logic [CharW-1:0] CH_STAR  = 8'h2a;
   localparam logic [CharW-1:0] CH_DOT   = 8'h2e;
   localparam logic [CharW-1:0] CH_PCT   = 8'h25;
   localparam logic [CharW-1:0] CH_UPX   = 8'h58;
   localparam logic [CharW-1:0] CH_C     = 8'h63;
   localparam logic [CharW-1:0] CH_S     = 8'h73;
   localparam logic [CharW-1:0] CH_P     = 8'h70;
   localparam logic [CharW-1:0] CH_D     = 8'h64;
   localparam logic [CharW-1:0] CH_I     = 8'h69;
   localparam logic [CharW-1:0] CH_U     = 8'h75;
   localparam logic [CharW-1:0] CH_X     = 8'h78;

   localparam logic REQ_CHAR = 1'b0;
   localparam logic REQ_ARG  = 1'b1;

   typedef enum logic [1:0] {
      FLAG_NONE = 2'd0,
      FLAG_ZERO = 2'd1,
      FLAG_LEFT = 2'd2
   } flag_type;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_FLAGS  = 3'd1,
      PH_WDIG   = 3'd2,
      PH_ARG    = 3'd3,
      PH_DOT    = 3'd4,
      PH_PFIRST = 3'd5,
      PH_PDIG   = 3'd6,
      PH_SPEC   = 3'd7
   } phase_type;

   typedef struct packed {
      logic                    req_type;
      logic [CharW-1:0]        char_code;
      logic signed [ArgW-1:0]  arg_value;
   } fsp_req_type;

   typedef struct packed {
      logic                    ok;
      logic [1:0]              flag_mode;
      logic [WidthW-1:0]       field_width;
      logic signed [PrecW-1:0] precision_value;
      logic [CharW-1:0]        specifier;
      logic [CountW-1:0]       consumed;
   } fsp_rsp_type;

   function automatic logic is_digit(input logic [CharW-1:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_spec(input logic [CharW-1:0] c);
      return (c == CH_C) || (c == CH_S) || (c == CH_P) || (c == CH_D) || (c == CH_I) ||
             (c == CH_U) || (c == CH_X) || (c == CH_UPX) || (c == CH_PCT);
   endfunction

   // acc * 10 + digit, saturating
   function automatic logic [WidthW-1:0] add_digit(input logic [WidthW-1:0] acc,
                                                    input logic [CharW-1:0]  c);
      logic [WidthW+3:0] wide;
      wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{(WidthW){1'b0}}, c[3:0]};
      return (wide > {4'b0, WIDTH_MAX}) ? WIDTH_MAX : wide[WidthW-1:0];
   endfunction

endpackage

[src/fsp_in_stage.sv]
// fsp_in_stage: input request register with stall generation.
// Depends on fsp_pkg.
module fsp_in_stage
   import fsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  fsp_req_type req_data,
   input  logic        advance,
   output logic        item_valid,
   output fsp_req_type item
);

   logic        valid_ff, valid_in;
   fsp_req_type data_ff, data_in;
   logic        take;

   assign req_stall = valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (take) begin
         valid_in = 1'b1;
         data_in  = req_data;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign item_valid = valid_ff;
   assign item       = data_ff;

endmodule

[src/fsp_parser.sv]
// fsp_parser: parse state registers and the per-request state update.
// Depends on fsp_pkg.
module fsp_parser
   import fsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  fsp_req_type item,
   output logic        emit,
   output fsp_rsp_type result
);

   phase_type          phase_ff, phase_in;
   flag_type           flag_ff, flag_in;
   logic [WidthW-1:0]  width_ff, width_in;
   logic [PrecW-1:0]   prec_ff, prec_in;
   logic [CountW-1:0]  cnt_ff, cnt_in;

   logic [CountW-1:0]  cnt_inc;
   logic [ArgW-1:0]    mag;

   always_comb begin
      logic [CharW-1:0] c;
      logic do_ws;
      logic do_dc;
      logic do_fin;
      c      = item.char_code;
      do_ws  = 1'b0;
      do_dc  = 1'b0;
      do_fin = 1'b0;
      cnt_inc = (cnt_ff == COUNT_MAX) ? cnt_ff : cnt_ff + 1'b1;
      mag     = '0 - item.arg_value;
      phase_in = phase_ff;
      flag_in  = flag_ff;
      width_in = width_ff;
      prec_in  = prec_ff;
      cnt_in   = cnt_ff;
      emit     = 1'b0;
      result   = '0;

      if (phase_ff == PH_ARG) begin
         if (item.req_type == REQ_ARG) begin
            if (prec_ff == PREC_NONE) begin
               if (item.arg_value[ArgW-1]) begin
                  flag_in  = FLAG_LEFT;
                  width_in = mag[ArgW-1] ? WIDTH_MAX : mag[WidthW-1:0];
               end else begin
                  width_in = item.arg_value[WidthW-1:0];
               end
               phase_in = PH_DOT;
            end else begin
               prec_in  = item.arg_value[ArgW-1] ? PREC_NONE : item.arg_value;
               phase_in = PH_SPEC;
            end
         end
      end else if (item.req_type == REQ_CHAR) begin
         unique case (phase_ff)
            PH_IDLE: begin
               cnt_in   = cnt_inc;
               phase_in = PH_FLAGS;
            end
            PH_FLAGS: begin
               if (c == CH_MINUS) begin
                  cnt_in  = cnt_inc;
                  flag_in = FLAG_LEFT;
               end else if (c == CH_ZERO) begin
                  cnt_in = cnt_inc;
                  if (flag_ff == FLAG_NONE) flag_in = FLAG_ZERO;
               end else begin
                  do_ws = 1'b1;
               end
            end
            PH_WDIG: begin
               if (is_digit(c)) begin
                  cnt_in   = cnt_inc;
                  width_in = add_digit(width_ff, c);
               end else begin
                  do_dc = 1'b1;
               end
            end
            PH_DOT: do_dc = 1'b1;
            PH_PFIRST: begin
               if (c == CH_STAR) begin
                  cnt_in   = cnt_inc;
                  phase_in = PH_ARG;
               end else if (is_digit(c)) begin
                  cnt_in   = cnt_inc;
                  prec_in  = {1'b0, add_digit(prec_ff[WidthW-1:0], c)};
                  phase_in = PH_PDIG;
               end else begin
                  do_fin = 1'b1;
               end
            end
            PH_PDIG: begin
               if (is_digit(c)) begin
                  cnt_in  = cnt_inc;
                  prec_in = {1'b0, add_digit(prec_ff[WidthW-1:0], c)};
               end else begin
                  do_fin = 1'b1;
               end
            end
            PH_SPEC: do_fin = 1'b1;
            PH_ARG:  do_fin = 1'b0;
            default: do_fin = 1'b0;
         endcase

         if (do_ws) begin
            if (c == CH_STAR) begin
               cnt_in   = cnt_inc;
               phase_in = PH_ARG;
            end else if (is_digit(c)) begin
               cnt_in   = cnt_inc;
               width_in = add_digit(width_ff, c);
               phase_in = PH_WDIG;
            end else begin
               do_dc = 1'b1;
            end
         end

         if (do_dc) begin
            if (c == CH_DOT) begin
               cnt_in   = cnt_inc;
               prec_in  = '0;
               phase_in = PH_PFIRST;
            end else begin
               do_fin = 1'b1;
            end
         end

         if (do_fin) begin
            emit            = 1'b1;
            result.consumed = cnt_inc;
            if (is_spec(c)) begin
               result.ok              = 1'b1;
               result.flag_mode       = flag_ff;
               result.field_width     = width_ff;
               result.precision_value = prec_ff;
               result.specifier       = c;
            end
            phase_in = PH_IDLE;
            flag_in  = FLAG_NONE;
            width_in = '0;
            prec_in  = PREC_NONE;
            cnt_in   = '0;
         end
      end

      if (!step) begin
         emit     = 1'b0;
         phase_in = phase_ff;
         flag_in  = flag_ff;
         width_in = width_ff;
         prec_in  = prec_ff;
         cnt_in   = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         flag_ff  <= FLAG_NONE;
         width_ff <= '0;
         prec_ff  <= PREC_NONE;
         cnt_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         flag_ff  <= flag_in;
         width_ff <= width_in;
         prec_ff  <= prec_in;
         cnt_ff   <= cnt_in;
      end
   end

   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (cnt_ff == '0 && width_ff == '0 &&
                                 prec_ff == PREC_NONE && flag_ff == FLAG_NONE))
      else $error("idle phase with stale parse state");

   a_emit_ends: assert property (@(posedge clock) disable iff (reset)
      emit |=> (phase_ff == PH_IDLE))
      else $error("result did not end the conversion");

   a_busy_counted: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_IDLE) |-> (cnt_ff != '0))
      else $error("open conversion with zero count");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(phase_ff) && $stable(cnt_ff))
      else $error("state moved without a request");

endmodule

[src/format_specifier_parser_core.sv]
// Printf conversion specifier parser, one format character or star argument per request.
// Each request is held in the input register; a result that it completes is then held
// in the result register. Throughput: one request per cycle while the receiver does not stall.
// Reset (synchronous, active high) empties both registers and returns the parser to
// awaiting the introducer. Depends on fsp_pkg, fsp_in_stage, fsp_parser.
module format_specifier_parser_core
   import fsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  fsp_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output fsp_rsp_type rsp_data
);

   logic        item_valid;
   fsp_req_type item;
   logic        out_free;
   logic        advance;
   logic        emit;
   fsp_rsp_type result;

   logic        rsp_valid_ff, rsp_valid_in;
   fsp_rsp_type rsp_data_ff, rsp_data_in;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign advance  = item_valid && out_free;

   fsp_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   fsp_parser u_parse (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item),
      .emit   (emit),
      .result (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[tb/tb_format_specifier_parser_core.sv]
// Testbench for format_specifier_parser_core: directed and random printf conversions,
// checked result by result against an in-bench model of the parser.
// Depends on fsp_pkg and the format_specifier_parser_core RTL.
module tb_format_specifier_parser_core;
   timeunit 1ns;
   timeprecision 1ps;
   import fsp_pkg::*;

   localparam int CycleLimit = 200000;
   localparam int RandomItems = 760;

   typedef struct {
      fsp_req_type req;
      bit          drain;
   } stim_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   fsp_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   fsp_rsp_type rsp_data;

   stim_type    format_chars_q[$];
   fsp_rsp_type spec_results_q[$];
   stim_type    next_stim;
   fsp_rsp_type want;
   bit          drain_next = 1'b0;
   int          stim_count = 0;
   int          total_items = 0;
   int          accepted_cnt = 0;
   int          err_count = 0;
   int          cycle_cnt = 0;
   int          hold_left = 0;
   bit          hold_done = 1'b0;
   logic        calm;

   // parser model state
   phase_type          ph = PH_IDLE;
   flag_type           flag_q = FLAG_NONE;
   logic [WidthW-1:0]  width_q = '0;
   logic signed [31:0] prec_q = -1;
   logic [CountW-1:0]  count_q = '0;

   logic [CharW-1:0] spec_set [9] = '{CH_C, CH_S, CH_P, CH_D, CH_I, CH_U, CH_X, CH_UPX, CH_PCT};

   format_specifier_parser_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2ns clock = ~clock;

   assign calm = (accepted_cnt >= 400) && (accepted_cnt < 600);

   function automatic bit is_dec(input logic [CharW-1:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic [WidthW-1:0] digit_acc(input logic [WidthW-1:0] acc,
                                                   input logic [CharW-1:0]  c);
      logic [35:0] sum;
      sum = 36'(acc) * 36'd10 + 36'(c[3:0]);
      return (sum > 36'(WIDTH_MAX)) ? WIDTH_MAX : sum[WidthW-1:0];
   endfunction

   function automatic string fmt_rsp(input fsp_rsp_type r);
      return $sformatf("ok=%0d flag=%0d width=%0d prec=%0d spec=%02h consumed=%0d",
                       r.ok, r.flag_mode, r.field_width, r.precision_value, r.specifier,
                       r.consumed);
   endfunction

   task automatic clear_parse();
      ph = PH_IDLE;
      flag_q = FLAG_NONE;
      width_q = '0;
      prec_q = -1;
      count_q = '0;
   endtask

   task automatic bump();
      if (count_q != COUNT_MAX) count_q++;
   endtask

   task automatic end_spec(input logic [CharW-1:0] c);
      fsp_rsp_type r;
      bump();
      r = '0;
      r.consumed = count_q;
      if (c inside {CH_C, CH_S, CH_P, CH_D, CH_I, CH_U, CH_X, CH_UPX, CH_PCT}) begin
         r.ok = 1'b1;
         r.flag_mode = flag_q;
         r.field_width = width_q;
         r.precision_value = prec_q;
         r.specifier = c;
      end
      spec_results_q.push_back(r);
      clear_parse();
   endtask

   task automatic dot_or_end(input logic [CharW-1:0] c);
      if (c == CH_DOT) begin
         bump();
         prec_q = 0;
         ph = PH_PFIRST;
      end else begin
         end_spec(c);
      end
   endtask

   task automatic step_parser(input fsp_req_type rq);
      logic [CharW-1:0]   c;
      logic signed [63:0] v;
      c = rq.char_code;
      v = {{32{rq.arg_value[31]}}, rq.arg_value};
      if (ph == PH_ARG) begin
         if (rq.req_type == REQ_ARG) begin
            if (prec_q == -1) begin
               if (v < 0) begin
                  v = -v;
                  flag_q = FLAG_LEFT;
               end
               width_q = (v > 64'sh7fff_ffff) ? WIDTH_MAX : v[WidthW-1:0];
               ph = PH_DOT;
            end else begin
               prec_q = (v < 0) ? -1 : rq.arg_value;
               ph = PH_SPEC;
            end
         end
         return;
      end
      if (rq.req_type != REQ_CHAR) return;
      case (ph)
         PH_IDLE: begin
            bump();
            ph = PH_FLAGS;
         end
         PH_FLAGS: begin
            if (c == CH_MINUS) begin
               bump();
               flag_q = FLAG_LEFT;
            end else if (c == CH_ZERO) begin
               bump();
               if (flag_q == FLAG_NONE) flag_q = FLAG_ZERO;
            end else if (c == CH_STAR) begin
               bump();
               ph = PH_ARG;
            end else if (is_dec(c)) begin
               bump();
               width_q = digit_acc(width_q, c);
               ph = PH_WDIG;
            end else begin
               dot_or_end(c);
            end
         end
         PH_WDIG: begin
            if (is_dec(c)) begin
               bump();
               width_q = digit_acc(width_q, c);
            end else begin
               dot_or_end(c);
            end
         end
         PH_DOT: dot_or_end(c);
         PH_PFIRST: begin
            if (c == CH_STAR) begin
               bump();
               ph = PH_ARG;
            end else if (is_dec(c)) begin
               bump();
               prec_q = {1'b0, digit_acc(prec_q[30:0], c)};
               ph = PH_PDIG;
            end else begin
               end_spec(c);
            end
         end
         PH_PDIG: begin
            if (is_dec(c)) begin
               bump();
               prec_q = {1'b0, digit_acc(prec_q[30:0], c)};
            end else begin
               end_spec(c);
            end
         end
         default: end_spec(c);
      endcase
   endtask

   // stimulus building
   function automatic void push_req(input logic typ, input logic [CharW-1:0] c,
                                    input logic [31:0] a, input bit counted);
      stim_type s;
      s.req.req_type = typ;
      s.req.char_code = c;
      s.req.arg_value = a;
      s.drain = drain_next;
      drain_next = 1'b0;
      format_chars_q.push_back(s);
      if (counted) stim_count++;
   endfunction

   function automatic void push_char(input logic [CharW-1:0] c, input bit counted = 1'b1);
      push_req(REQ_CHAR, c, $urandom, counted);
   endfunction

   function automatic void push_arg(input logic [31:0] a, input bit counted = 1'b1);
      push_req(REQ_ARG, 8'($urandom_range(255)), a, counted);
   endfunction

   function automatic logic [CharW-1:0] rand_digit();
      return CH_ZERO + 8'($urandom_range(9));
   endfunction

   function automatic logic [31:0] rand_arg();
      case ($urandom_range(4))
         0: return $urandom_range(60);
         1: return 32'd0 - $urandom_range(60, 1);
         2: begin
            case ($urandom_range(3))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'hffff_ffff;
               default: return 32'd0;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   function automatic void push_star();
      push_char(CH_STAR);
      if ($urandom_range(9) == 0) push_char(8'($urandom_range(255)), 1'b0);
      push_arg(rand_arg());
   endfunction

   function automatic void gen_conversion();
      int unsigned mode;
      bit          star_width;
      mode = $urandom_range(99);
      star_width = 1'b0;
      if (mode < 8) begin
         repeat ($urandom_range(4, 1))
            if ($urandom_range(1)) push_arg($urandom);
            else push_char(8'($urandom_range(255)));
         return;
      end
      push_char($urandom_range(1) ? CH_PCT : 8'($urandom_range(255)));
      if ($urandom_range(9) == 0) push_arg($urandom, 1'b0);
      repeat ($urandom_range(3)) push_char($urandom_range(1) ? CH_ZERO : CH_MINUS);
      case ($urandom_range(4))
         1: repeat ($urandom_range(4, 1)) push_char(rand_digit());
         2: repeat ($urandom_range(14, 9)) push_char(rand_digit());
         3, 4: begin
            push_star();
            star_width = 1'b1;
         end
         default: ;
      endcase
      if (star_width && mode < 16) push_char(rand_digit());
      if ($urandom_range(99) < 60) begin
         push_char(CH_DOT);
         case ($urandom_range(3))
            1: repeat ($urandom_range(4, 1)) push_char(rand_digit());
            2: repeat ($urandom_range(12, 10)) push_char(rand_digit());
            3: push_star();
            default: ;
         endcase
      end
      if ($urandom_range(99) < 85) push_char(spec_set[$urandom_range(8)]);
      else push_char(8'($urandom_range(255)));
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            step_parser(req_data);
            accepted_cnt <= accepted_cnt + 1;
         end
         if (!req_valid || !req_stall) begin
            if (format_chars_q.size() != 0 &&
                !(format_chars_q[0].drain && spec_results_q.size() != 0) &&
                (calm || $urandom_range(99) >= 29)) begin
               next_stim = format_chars_q.pop_front();
               req_data <= next_stim.req;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, once
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && accepted_cnt >= 300) begin
         hold_left <= 300;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (spec_results_q.size() == 0) begin
               err_count++;
               if (err_count <= 10) $display("unexpected result: %s", fmt_rsp(rsp_data));
            end else begin
               want = spec_results_q.pop_front();
               if (rsp_data.ok !== want.ok || rsp_data.flag_mode !== want.flag_mode ||
                   rsp_data.field_width !== want.field_width ||
                   rsp_data.precision_value !== want.precision_value ||
                   rsp_data.specifier !== want.specifier ||
                   rsp_data.consumed !== want.consumed) begin
                  err_count++;
                  if (err_count <= 10) begin
                     $display("mismatch expected: %s", fmt_rsp(want));
                     $display("         actual:   %s", fmt_rsp(rsp_data));
                  end
               end
            end
         end
         rsp_stall <= (hold_left != 0) || (!calm && $urandom_range(99) < 29);
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      // stray argument, star width at the most negative value, stray char while
      // awaiting an argument, negative star precision
      push_arg(32'd123, 1'b0);
      push_char(CH_PCT);
      push_char(CH_STAR);
      push_char("q", 1'b0);
      push_arg(32'h8000_0000);
      push_char(CH_DOT);
      push_char(CH_STAR);
      push_arg(32'd0 - 32'd5);
      push_char(CH_UPX);
      // dot without digits
      push_char(CH_PCT);
      push_char(CH_ZERO);
      push_char(CH_DOT);
      push_char(CH_C);
      // digit after a star width
      push_char(CH_PCT);
      push_char(CH_STAR);
      push_arg(32'h7fff_ffff);
      push_char(CH_ZERO + 8'd3);
      push_char(CH_PCT);
      push_char(CH_MINUS);
      push_char(CH_ZERO);
      push_char(CH_NINE);
      push_char(CH_DOT);
      push_char(CH_NINE);
      push_char(CH_P);
      drain_next = 1'b1;
      stim_count = 0;
      while (stim_count < RandomItems) gen_conversion();
      total_items = format_chars_q.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      while (accepted_cnt != total_items || spec_results_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (err_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
